@@ rtl/hex_profile_text_decoder_defines.svh @@
// assertion macros for the hex profile text decoder checker
// no dependencies; included by the checker file only
`ifndef HEX_PROFILE_TEXT_DECODER_DEFINES_SVH
`define HEX_PROFILE_TEXT_DECODER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define HPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hpd check failed");

// next-cycle implication, disabled while in reset
`define HPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hpd check failed");

// check that is live during reset as well
`define HPD_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("hpd check failed");

`endif

@@ rtl/hpd_pkg.sv @@
// shared types, character codes and result struct for the hex profile decoder
// no dependencies
`timescale 1ns / 1ps

package hpd_pkg;

  localparam int LENGTH_BITS_DEF = 24;

  typedef enum logic [2:0] {
    PH_SKIP_FIRST = 3'd0,
    PH_FIND_NL    = 3'd1,
    PH_SKIP_WS    = 3'd2,
    PH_NUM_LEAD   = 3'd3,
    PH_NUM_BODY   = 3'd4,
    PH_HEX        = 3'd5,
    PH_DONE       = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_DATA   = 2'd2
  } err_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [3:0] HEX_A_VAL = 4'd10;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    err_t       err;
  } res_t;

endpackage

@@ rtl/hpd_in_if.sv @@
// input character channel: valid/ready with one text byte and a last flag
// no dependencies
`timescale 1ns / 1ps

interface hpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/hpd_out_if.sv @@
// result channel: valid/ready with decoded byte, last flag and error code
// no dependencies
`timescale 1ns / 1ps

interface hpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] error_code;

  modport source (output valid, output out_byte, output out_last, output error_code,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input error_code,
                  output ready);
endinterface

@@ rtl/hex_profile_text_decoder.sv @@
// top level of the hex profile text decoder
// depends on hpd_pkg, hpd_in_if, hpd_out_if and hpd_step
//
// Usage:
//   in_ch carries one character of profile text per transfer (in_byte) with
//   in_last set on the final character of a profile. out_ch carries decoded
//   bytes (out_byte), out_last on the final byte or on an error, and
//   error_code (0 ok, 1 invalid length, 2 ran out of data).
//   A character's result, if any, is in the output register the cycle after
//   its input transfer. One character is accepted every cycle while in_ready
//   is high; the rate is set by the single state update between the state
//   registers and the output register.
//   in_ready is high while the output register is empty or is being read in
//   the same cycle, so a stalled receiver holds the result and blocks new
//   input only while a result is waiting.
//   Reset (rst_n low, synchronous) empties the output register and puts the
//   parser back at the first character of a profile. The character marked
//   last also returns the parser to that state.
`timescale 1ns / 1ps

module hex_profile_text_decoder #(
  parameter int LENGTH_BITS = hpd_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hpd_in_if.sink     in_ch,
  hpd_out_if.source  out_ch
);

  hpd_pkg::phase_t        phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic                   len_neg_r, len_neg_nxt;
  logic                   len_ovf_r, len_ovf_nxt;
  logic                   num_ended_r, num_ended_nxt;
  logic [LENGTH_BITS:0]   nib_cnt_r, nib_cnt_nxt;
  logic [3:0]             hi_nib_r, hi_nib_nxt;
  hpd_pkg::res_t          res;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [1:0] out_err_r;
  logic       in_xfer;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  hpd_step #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .phase         (phase_r),
    .len           (len_r),
    .len_neg       (len_neg_r),
    .len_ovf       (len_ovf_r),
    .num_ended     (num_ended_r),
    .nib_cnt       (nib_cnt_r),
    .hi_nib        (hi_nib_r),
    .ch            (in_ch.in_byte),
    .ch_last       (in_ch.in_last),
    .phase_nxt     (phase_nxt),
    .len_nxt       (len_nxt),
    .len_neg_nxt   (len_neg_nxt),
    .len_ovf_nxt   (len_ovf_nxt),
    .num_ended_nxt (num_ended_nxt),
    .nib_cnt_nxt   (nib_cnt_nxt),
    .hi_nib_nxt    (hi_nib_nxt),
    .res           (res)
  );

  always_comb begin
    if (in_xfer) begin
      out_valid_nxt = res.valid;
    end else begin
      out_valid_nxt = out_valid_r && !out_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= hpd_pkg::PH_SKIP_FIRST;
      len_r       <= '0;
      len_neg_r   <= 1'b0;
      len_ovf_r   <= 1'b0;
      num_ended_r <= 1'b0;
      nib_cnt_r   <= '0;
      hi_nib_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        phase_r     <= phase_nxt;
        len_r       <= len_nxt;
        len_neg_r   <= len_neg_nxt;
        len_ovf_r   <= len_ovf_nxt;
        num_ended_r <= num_ended_nxt;
        nib_cnt_r   <= nib_cnt_nxt;
        hi_nib_r    <= hi_nib_nxt;
      end
    end
  end

  // payload only loads when a new result takes the slot
  always_ff @(posedge clk) begin
    if (in_xfer && res.valid) begin
      out_byte_r <= res.data;
      out_last_r <= res.last;
      out_err_r  <= res.err;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.out_last   = out_last_r;
  assign out_ch.error_code = out_err_r;

endmodule

@@ rtl/hpd_step.sv @@
// per-character next-state and result logic of the hex profile decoder
// depends on hpd_pkg
`timescale 1ns / 1ps

module hpd_step #(
  parameter int LENGTH_BITS = hpd_pkg::LENGTH_BITS_DEF
) (
  input  hpd_pkg::phase_t         phase,
  input  logic [LENGTH_BITS-1:0]  len,
  input  logic                    len_neg,
  input  logic                    len_ovf,
  input  logic                    num_ended,
  input  logic [LENGTH_BITS:0]    nib_cnt,
  input  logic [3:0]              hi_nib,
  input  logic [7:0]              ch,
  input  logic                    ch_last,
  output hpd_pkg::phase_t         phase_nxt,
  output logic [LENGTH_BITS-1:0]  len_nxt,
  output logic                    len_neg_nxt,
  output logic                    len_ovf_nxt,
  output logic                    num_ended_nxt,
  output logic [LENGTH_BITS:0]    nib_cnt_nxt,
  output logic [3:0]              hi_nib_nxt,
  output hpd_pkg::res_t           res
);

  logic                   is_digit;
  logic                   is_lhex;
  logic                   is_sep;
  logic                   is_lead_ws;
  logic [3:0]             nib_val;
  logic [LENGTH_BITS+3:0] len_x10;
  logic                   x10_too_big;
  logic [LENGTH_BITS:0]   cnt_inc;
  logic                   fin;
  logic                   lead;

  assign is_digit   = (ch >= hpd_pkg::CH_0) && (ch <= hpd_pkg::CH_9);
  assign is_lhex    = (ch >= hpd_pkg::CH_A) && (ch <= hpd_pkg::CH_F);
  assign is_sep     = (ch == hpd_pkg::CH_SP) || (ch == hpd_pkg::CH_NL);
  assign is_lead_ws = (ch == hpd_pkg::CH_TAB) || (ch == hpd_pkg::CH_VT) ||
                      (ch == hpd_pkg::CH_FF) || (ch == hpd_pkg::CH_CR);
  // low nibble of '0'..'9' is the value; 'a'..'f' have low nibble 1..6
  assign nib_val    = is_digit ? ch[3:0] : 4'(ch[3:0] + (hpd_pkg::HEX_A_VAL - 4'd1));

  // len*10 + digit by shift and add, overflow if anything lands above the field
  assign len_x10 = {1'b0, len, 3'b000} + {3'b000, len, 1'b0} +
                   {{LENGTH_BITS{1'b0}}, ch[3:0]};
  assign x10_too_big = |len_x10[LENGTH_BITS+3:LENGTH_BITS];

  assign cnt_inc = nib_cnt + {{LENGTH_BITS{1'b0}}, 1'b1};
  assign fin     = cnt_inc >= {len, 1'b0};

  always_comb begin
    phase_nxt     = phase;
    len_nxt       = len;
    len_neg_nxt   = len_neg;
    len_ovf_nxt   = len_ovf;
    num_ended_nxt = num_ended;
    nib_cnt_nxt   = nib_cnt;
    hi_nib_nxt    = hi_nib;
    res           = '0;
    lead          = (phase == hpd_pkg::PH_SKIP_WS) || (phase == hpd_pkg::PH_NUM_LEAD);

    case (phase)
      hpd_pkg::PH_SKIP_FIRST: begin
        phase_nxt = hpd_pkg::PH_FIND_NL;
      end
      hpd_pkg::PH_FIND_NL: begin
        if (ch == hpd_pkg::CH_NL) begin
          phase_nxt = hpd_pkg::PH_SKIP_WS;
        end
      end
      hpd_pkg::PH_SKIP_WS, hpd_pkg::PH_NUM_LEAD, hpd_pkg::PH_NUM_BODY: begin
        if (phase == hpd_pkg::PH_SKIP_WS && (ch == hpd_pkg::CH_NUL || is_sep)) begin
          phase_nxt = phase;
        end else if (is_sep) begin
          if (len_neg || len_ovf || len == '0) begin
            res.valid = 1'b1;
            res.last  = 1'b1;
            res.err   = hpd_pkg::ERR_LENGTH;
            phase_nxt = hpd_pkg::PH_DONE;
          end else begin
            nib_cnt_nxt = '0;
            phase_nxt   = hpd_pkg::PH_HEX;
          end
        end else if (lead) begin
          phase_nxt = hpd_pkg::PH_NUM_LEAD;
          if (is_lead_ws) begin
            phase_nxt = hpd_pkg::PH_NUM_LEAD;
          end else if (ch == hpd_pkg::CH_PLUS || ch == hpd_pkg::CH_MINUS) begin
            len_neg_nxt = (ch == hpd_pkg::CH_MINUS);
            phase_nxt   = hpd_pkg::PH_NUM_BODY;
          end else if (is_digit) begin
            if (x10_too_big) begin
              len_ovf_nxt = 1'b1;
            end else begin
              len_nxt = len_x10[LENGTH_BITS-1:0];
            end
            phase_nxt = hpd_pkg::PH_NUM_BODY;
          end else begin
            num_ended_nxt = 1'b1;
            phase_nxt     = hpd_pkg::PH_NUM_BODY;
          end
        end else begin
          if (!num_ended && is_digit) begin
            if (x10_too_big) begin
              len_ovf_nxt = 1'b1;
            end else begin
              len_nxt = len_x10[LENGTH_BITS-1:0];
            end
          end else begin
            num_ended_nxt = 1'b1;
          end
        end
      end
      hpd_pkg::PH_HEX: begin
        if (ch == hpd_pkg::CH_NUL) begin
          res.valid = 1'b1;
          res.last  = 1'b1;
          res.err   = hpd_pkg::ERR_DATA;
          phase_nxt = hpd_pkg::PH_DONE;
        end else if (is_digit || is_lhex) begin
          nib_cnt_nxt = cnt_inc;
          if (!nib_cnt[0]) begin
            hi_nib_nxt = nib_val;
          end else begin
            res.valid = 1'b1;
            res.data  = {hi_nib, nib_val};
            res.last  = fin;
            res.err   = hpd_pkg::ERR_OK;
            if (fin) begin
              phase_nxt = hpd_pkg::PH_DONE;
            end
          end
        end
      end
      default: begin
        phase_nxt = phase;
      end
    endcase

    // end of the text: report a short profile, then start afresh
    if (ch_last) begin
      if (!res.valid && phase_nxt != hpd_pkg::PH_DONE) begin
        res.valid = 1'b1;
        res.data  = '0;
        res.last  = 1'b1;
        res.err   = hpd_pkg::ERR_DATA;
      end
      phase_nxt     = hpd_pkg::PH_SKIP_FIRST;
      len_nxt       = '0;
      len_neg_nxt   = 1'b0;
      len_ovf_nxt   = 1'b0;
      num_ended_nxt = 1'b0;
      nib_cnt_nxt   = '0;
      hi_nib_nxt    = '0;
    end
  end

endmodule

@@ rtl/hpd_checker.sv @@
// port-level checks for the hex profile text decoder, bound to the top level
// depends on hex_profile_text_decoder_defines.svh and hex_profile_text_decoder
`timescale 1ns / 1ps
`include "hex_profile_text_decoder_defines.svh"

module hpd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic [1:0] error_code
);

  // a waiting result holds until its transfer
  `HPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last) && $stable(error_code))

  // no input is taken while the output register is full and stalled
  `HPD_ASSERT_NOW(a_no_overrun, clk, rst_n, out_valid && !out_ready, !in_ready)

  // error results are closing zero bytes, and code 3 never appears
  `HPD_ASSERT_NOW(a_err_form, clk, rst_n, out_valid && error_code != 2'd0, out_byte == 8'h00 && out_last && error_code != 2'd3)

  // the output register is empty straight after reset
  `HPD_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n), !out_valid)

  // a result appears only after an input transfer
  `HPD_ASSERT_NEXT(a_cause, clk, rst_n, !out_valid && !(in_valid && in_ready), !out_valid)

endmodule

bind hex_profile_text_decoder hpd_checker u_hpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .out_last   (out_ch.out_last),
  .error_code (out_ch.error_code)
);

@@ tb/sv/tb_hex_profile_text_decoder.sv @@
// self-checking bench for hex_profile_text_decoder: directed profiles, then random ones
// depends on hpd_pkg, hpd_in_if, hpd_out_if and the decoder rtl
// an in-bench decode predictor queues the expected bytes and a monitor checks each transfer
`timescale 1ns / 1ps

module tb_hex_profile_text_decoder;

  localparam longint unsigned MAX_LEN = (64'd1 << hpd_pkg::LENGTH_BITS_DEF) - 1;

  typedef struct packed {
    logic [7:0]     data;
    logic           last;
    hpd_pkg::err_t  err;
  } decoded_t;

  class profile_decode_tracker;
    hpd_pkg::phase_t ph;
    logic [23:0] len;
    logic        neg;
    logic        ovf;
    logic        num_end;
    logic [24:0] nib;
    logic [3:0]  hi;
    decoded_t    expected_bytes[$];
    int          fails;

    function new();
      fails = 0;
      clear();
    endfunction

    function void clear();
      ph      = hpd_pkg::PH_SKIP_FIRST;
      len     = '0;
      neg     = 1'b0;
      ovf     = 1'b0;
      num_end = 1'b0;
      nib     = '0;
      hi      = '0;
    endfunction

    function bit is_dig(logic [7:0] b);
      return b >= hpd_pkg::CH_0 && b <= hpd_pkg::CH_9;
    endfunction

    function void add_digit(logic [7:0] b);
      longint unsigned t;
      t = longint'(len) * 10 + longint'(b - hpd_pkg::CH_0);
      if (t > MAX_LEN) ovf = 1'b1;
      else len = t[23:0];
    endfunction

    // predict what one accepted character produces
    function void note_char(logic [7:0] b, logic lst);
      decoded_t r;
      bit       got;
      bit       is_hex;
      bit       fin;
      logic [3:0] v;
      got = 0;
      r = '0;
      v = '0;
      case (ph)
        hpd_pkg::PH_SKIP_FIRST: ph = hpd_pkg::PH_FIND_NL;
        hpd_pkg::PH_FIND_NL: if (b == hpd_pkg::CH_NL) ph = hpd_pkg::PH_SKIP_WS;
        hpd_pkg::PH_SKIP_WS, hpd_pkg::PH_NUM_LEAD, hpd_pkg::PH_NUM_BODY: begin
          if (ph == hpd_pkg::PH_SKIP_WS && b != hpd_pkg::CH_NUL && b != hpd_pkg::CH_SP &&
              b != hpd_pkg::CH_NL) ph = hpd_pkg::PH_NUM_LEAD;
          if (ph != hpd_pkg::PH_SKIP_WS) begin
            if (b == hpd_pkg::CH_SP || b == hpd_pkg::CH_NL) begin
              if (neg || ovf || len == 0) begin
                r = '{8'h00, 1'b1, hpd_pkg::ERR_LENGTH};
                got = 1;
                ph = hpd_pkg::PH_DONE;
              end else begin
                nib = '0;
                ph = hpd_pkg::PH_HEX;
              end
            end else if (ph == hpd_pkg::PH_NUM_LEAD) begin
              if (b == hpd_pkg::CH_TAB || b == hpd_pkg::CH_VT || b == hpd_pkg::CH_FF ||
                  b == hpd_pkg::CH_CR) begin
                // leading whitespace
              end else if (b == hpd_pkg::CH_PLUS || b == hpd_pkg::CH_MINUS) begin
                neg = (b == hpd_pkg::CH_MINUS);
                ph = hpd_pkg::PH_NUM_BODY;
              end else if (is_dig(b)) begin
                add_digit(b);
                ph = hpd_pkg::PH_NUM_BODY;
              end else begin
                num_end = 1'b1;
                ph = hpd_pkg::PH_NUM_BODY;
              end
            end else if (!num_end && is_dig(b)) begin
              add_digit(b);
            end else begin
              num_end = 1'b1;
            end
          end
        end
        hpd_pkg::PH_HEX: begin
          if (b == hpd_pkg::CH_NUL) begin
            r = '{8'h00, 1'b1, hpd_pkg::ERR_DATA};
            got = 1;
            ph = hpd_pkg::PH_DONE;
          end else begin
            is_hex = 1;
            if (is_dig(b)) v = 4'(b - hpd_pkg::CH_0);
            else if (b >= hpd_pkg::CH_A && b <= hpd_pkg::CH_F)
              v = 4'(b - hpd_pkg::CH_A + hpd_pkg::HEX_A_VAL);
            else is_hex = 0;
            if (is_hex) begin
              if (nib[0] == 1'b0) begin
                hi = v;
                nib = nib + 25'd1;
              end else begin
                nib = nib + 25'd1;
                fin = nib >= {len, 1'b0};
                r = '{{hi, v}, fin, hpd_pkg::ERR_OK};
                got = 1;
                if (fin) ph = hpd_pkg::PH_DONE;
              end
            end
          end
        end
        default: ;
      endcase
      if (lst) begin
        if (!got && ph != hpd_pkg::PH_DONE) begin
          r = '{8'h00, 1'b1, hpd_pkg::ERR_DATA};
          got = 1;
        end
        clear();
      end
      if (got) expected_bytes.push_back(r);
    endfunction

    function void check_result(logic [7:0] data, logic last, logic [1:0] err);
      decoded_t e;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result byte %02h last %0b err %0d", $time, data, last, err);
        fails++;
        return;
      end
      e = expected_bytes.pop_front();
      if (data !== e.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, e.data, data);
        fails++;
      end
      if (last !== e.last) begin
        $display("%0t: out_last expected %0b actual %0b", $time, e.last, last);
        fails++;
      end
      if (err !== e.err) begin
        $display("%0t: error_code expected %0d actual %0d", $time, e.err, err);
        fails++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  hpd_in_if  in_ch();
  hpd_out_if out_ch();

  hex_profile_text_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  profile_decode_tracker tracker = new();

  logic [7:0] text_buf[$];
  int         chars_sent = 0;
  bit         hold_req   = 0;
  bit         rx_holding = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.in_byte   <= 8'h00;
    in_ch.in_last   <= 1'b0;
    out_ch.ready    <= 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int g;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req   = 0;
        rx_holding = 1;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        rx_holding = 0;
      end
      g = idle_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // transfers are sampled before this edge's updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        tracker.check_result(out_ch.out_byte, out_ch.out_last, out_ch.error_code);
      if (in_ch.valid && in_ch.ready)
        tracker.note_char(in_ch.in_byte, in_ch.in_last);
    end
  end

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while ((c >= hpd_pkg::CH_0 && c <= hpd_pkg::CH_9) ||
           (c >= hpd_pkg::CH_A && c <= hpd_pkg::CH_F));
    return c;
  endfunction

  function automatic logic [7:0] nibble_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(hpd_pkg::CH_0 + v);
    return 8'(hpd_pkg::CH_A + v - 10);
  endfunction

  // last is set on the final character of the buffer
  task automatic send_text(input bit no_gaps);
    int i;
    int g;
    for (i = 0; i < text_buf.size(); i++) begin
      g = (no_gaps || rx_holding) ? 0 : idle_len();
      if (g > 0) begin
        in_ch.valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
      in_ch.valid   <= 1'b1;
      in_ch.in_byte <= text_buf[i];
      in_ch.in_last <= (i == text_buf.size() - 1);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      chars_sent++;
    end
  endtask

  task automatic build_random_profile();
    int          r;
    int          n;
    int          i;
    int          nibbles;
    longint unsigned plen;
    string       s;
    logic [7:0]  c;
    text_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 12) begin
      n = $urandom_range(1, 12);
      repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    text_buf.push_back(8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3)) begin
      do c = 8'($urandom_range(0, 255));
      while (c == hpd_pkg::CH_NL);
      text_buf.push_back(c);
    end
    if ($urandom_range(0, 19) != 0) text_buf.push_back(hpd_pkg::CH_NL);
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 2))
        0: text_buf.push_back(hpd_pkg::CH_NUL);
        1: text_buf.push_back(hpd_pkg::CH_SP);
        default: text_buf.push_back(hpd_pkg::CH_NL);
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 3))
          0: text_buf.push_back(hpd_pkg::CH_TAB);
          1: text_buf.push_back(hpd_pkg::CH_VT);
          2: text_buf.push_back(hpd_pkg::CH_FF);
          default: text_buf.push_back(hpd_pkg::CH_CR);
        endcase
      end
    end
    r = $urandom_range(0, 99);
    if (r >= 90) text_buf.push_back(hpd_pkg::CH_MINUS);
    else if (r >= 70) text_buf.push_back(hpd_pkg::CH_PLUS);
    r = $urandom_range(0, 99);
    if (r < 80) begin
      plen = 64'($urandom_range(1, 6));
      if ($urandom_range(0, 9) == 0) add_text("00");
      $sformat(s, "%0d", plen);
      add_text(s);
    end else if (r < 85) begin
      plen = 0;
      if ($urandom_range(0, 1) == 0) add_text("0");
    end else if (r < 92) begin
      plen = 64'($urandom_range(1000, 32'(MAX_LEN)));
      $sformat(s, "%0d", plen);
      add_text(s);
    end else if (r < 96) begin
      plen = MAX_LEN;
      $sformat(s, "%0d", plen);
      add_text(s);
    end else begin
      plen = 0;
      if ($urandom_range(0, 1) == 0) add_text("16777216");
      else begin
        $sformat(s, "%0d", $urandom_range(100000000, 999999999));
        add_text(s);
      end
    end
    // junk after the digits stops the number but not the scan
    if ($urandom_range(0, 9) == 0) begin
      text_buf.push_back(noise_char());
      text_buf.push_back(8'(hpd_pkg::CH_0 + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 19) != 0)
      text_buf.push_back($urandom_range(0, 1) ? hpd_pkg::CH_SP : hpd_pkg::CH_NL);
    if (plen >= 1 && plen <= 6) nibbles = int'(2 * plen);
    else nibbles = $urandom_range(0, 6);
    if ($urandom_range(0, 9) == 0 && nibbles > 0) nibbles = $urandom_range(0, nibbles - 1);
    for (i = 0; i < nibbles; i++) begin
      if ($urandom_range(0, 99) < 15) text_buf.push_back(noise_char());
      if ($urandom_range(0, 99) < 3) text_buf.push_back(hpd_pkg::CH_NUL);
      text_buf.push_back(nibble_char());
    end
    repeat ($urandom_range(0, 2)) text_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plain profile, uppercase hex skipped, trailing byte after done
    text_buf.delete();
    text_buf.push_back(hpd_pkg::CH_NUL);
    text_buf.push_back(hpd_pkg::CH_NL);
    add_text("1");
    text_buf.push_back(hpd_pkg::CH_NL);
    add_text("aF0");
    text_buf.push_back(8'hff);
    send_text(0);

    // minus zero after a tab is an invalid length
    text_buf.delete();
    add_text("x");
    text_buf.push_back(hpd_pkg::CH_NL);
    text_buf.push_back(hpd_pkg::CH_TAB);
    add_text("-0 z");
    send_text(0);

    // one above the largest length
    text_buf.delete();
    text_buf.push_back(hpd_pkg::CH_NL);
    text_buf.push_back(hpd_pkg::CH_NL);
    add_text("16777216 0");
    send_text(0);

    // junk ends the number, then a nul in the hex body
    text_buf.delete();
    add_text("x");
    text_buf.push_back(hpd_pkg::CH_NL);
    text_buf.push_back(hpd_pkg::CH_SP);
    text_buf.push_back(hpd_pkg::CH_VT);
    add_text("+2q");
    text_buf.push_back(hpd_pkg::CH_NL);
    add_text("9");
    text_buf.push_back(hpd_pkg::CH_NUL);
    send_text(1);

    // stream ends on the very first character
    text_buf.delete();
    add_text("x");
    send_text(0);

    hold_req = 1;
    while (chars_sent < 735) begin
      build_random_profile();
      send_text($urandom_range(0, 3) == 0);
    end
    in_ch.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
